>>> hw/rtl/mmle_pkg.sv
// ----------------------------------------------------------------------------
// mmle_pkg: shared types and codes of the leader election block
// Action and result kind codes, table read select, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mmle_pkg;

  localparam logic [1:0] ACT_ENTRY      = 2'd0;
  localparam logic [1:0] ACT_CONNECT    = 2'd1;
  localparam logic [1:0] ACT_DISCONNECT = 2'd2;
  localparam logic [1:0] ACT_QUERY      = 2'd3;

  localparam logic KIND_LEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam int ID_WIDTH    = 4;
  localparam int CLOCK_WIDTH = 32;
  localparam int MASK_WIDTH  = 16;

  typedef enum logic [1:0] {
    ADDR_ITEM,
    ADDR_OWN,
    ADDR_PEND,
    ADDR_CNT
  } addr_sel_t;

  typedef struct packed {
    logic      item_ready;
    logic      cfg_ready;
    logic      merge;
    logic      peer_upd;
    logic      reach_init;
    logic      reach_step;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      emit_leader;
    logic      emit_entry;
    addr_sel_t addr_sel;
  } mmle_cmd_t;

  typedef struct packed {
    logic       item_fire;
    logic       cfg_valid;
    logic [1:0] act;
    logic       msg_last;
    logic       pend_any;
    logic       cur_known;
    logic       more_above;
    logic       cnt_last;
    logic       out_free;
  } mmle_stat_t;

endpackage

>>> hw/rtl/mmle_ifs.sv
// ----------------------------------------------------------------------------
// mmle_ifs: channel interfaces of the leader election block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface mmle_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [mmle_pkg::ID_WIDTH-1:0]        node_id;
  logic signed [mmle_pkg::CLOCK_WIDTH-1:0] node_clock;
  logic [mmle_pkg::MASK_WIDTH-1:0]      neighbour_mask;
  logic                                 message_last;

  modport source (output valid, action, node_id, node_clock, neighbour_mask,
                  message_last, input ready);
  modport sink (input valid, action, node_id, node_clock, neighbour_mask,
                message_last, output ready);
endinterface

interface mmle_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [mmle_pkg::ID_WIDTH-1:0]        leader_id;
  logic                                 leader_valid;
  logic [mmle_pkg::ID_WIDTH-1:0]        entry_id;
  logic signed [mmle_pkg::CLOCK_WIDTH-1:0] entry_clock;
  logic [mmle_pkg::MASK_WIDTH-1:0]      entry_mask;
  logic                                 last;

  modport source (output valid, kind, leader_id, leader_valid, entry_id,
                  entry_clock, entry_mask, last, input ready);
  modport sink (input valid, kind, leader_id, leader_valid, entry_id,
                entry_clock, entry_mask, last, output ready);
endinterface

interface mmle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mmle_pkg::ID_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/mesh_min_id_leader_election.sv
// ----------------------------------------------------------------------------
// mesh_min_id_leader_election: minimum-id leader election over a mesh table
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// The block keeps one table entry (clock, neighbour bitmap) per node id and
// handles one item at a time through a single table read port. A received
// entry that does not close a message gives no report. A query, or a
// received entry that closes a message, runs a reachability walk whose
// closure visits one newly reached node per cycle. A connect or disconnect
// walks the table one entry per cycle, while the result side does not
// stall, up to the last known entry. Only ids below the table depth take
// part; the depth is the smaller of MAX_NODES and 16. Configuration beats are
// taken only between items.
module mesh_min_id_leader_election #(
  parameter int MAX_NODES = 16
) (
  input logic            clk,
  input logic            rst,
  mmle_item_if.sink      item,
  mmle_result_if.source  result,
  mmle_cfg_if.sink       cfg
);

  localparam int TBL = (MAX_NODES < mmle_pkg::MASK_WIDTH) ? MAX_NODES
                                                          : mmle_pkg::MASK_WIDTH;

  mmle_pkg::mmle_cmd_t  cmd;
  mmle_pkg::mmle_stat_t stat;

  mmle_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mmle_dp #(
    .TBL (TBL)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat)
  );

`ifndef SYNTHESIS
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item beat accepted while an item is in progress");

  a_cfg_blocks_item: assert property (@(posedge clk) disable iff (rst)
    cfg.valid |-> !item.ready)
    else $error("item ready while a configuration beat is pending");

  a_leader_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind == mmle_pkg::KIND_LEADER |-> result.last)
    else $error("leader report not marked last");

  a_invalid_leader_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.leader_valid |-> result.leader_id == 4'd0)
    else $error("leader id nonzero without a valid leader");
`endif

endmodule

>>> hw/rtl/mmle_ctrl.sv
// ----------------------------------------------------------------------------
// mmle_ctrl: sequencer of the leader election block
// Steps through merge, peer update, reachability walk, leader report and
// table broadcast, issuing one command group to the datapath per cycle.
// ----------------------------------------------------------------------------
module mmle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mmle_pkg::mmle_stat_t stat,
  output mmle_pkg::mmle_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REACH_INIT,
    S_REACH,
    S_LEADER,
    S_BCAST
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.addr_sel = mmle_pkg::ADDR_ITEM;
    case (state)
      S_IDLE: begin
        cmd.cfg_ready  = 1'b1;
        cmd.item_ready = !stat.cfg_valid;
        if (stat.item_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.act)
          mmle_pkg::ACT_ENTRY: begin
            cmd.addr_sel = mmle_pkg::ADDR_ITEM;
            cmd.merge    = 1'b1;
            state_next   = stat.msg_last ? S_REACH_INIT : S_IDLE;
          end
          mmle_pkg::ACT_CONNECT, mmle_pkg::ACT_DISCONNECT: begin
            cmd.addr_sel = mmle_pkg::ADDR_OWN;
            cmd.peer_upd = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_next   = S_BCAST;
          end
          default: begin
            state_next = S_REACH_INIT;
          end
        endcase
      end
      S_REACH_INIT: begin
        cmd.addr_sel   = mmle_pkg::ADDR_OWN;
        cmd.reach_init = 1'b1;
        state_next     = S_REACH;
      end
      S_REACH: begin
        cmd.addr_sel = mmle_pkg::ADDR_PEND;
        if (stat.pend_any) begin
          cmd.reach_step = 1'b1;
        end else begin
          state_next = S_LEADER;
        end
      end
      S_LEADER: begin
        if (stat.out_free) begin
          cmd.emit_leader = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_BCAST: begin
        cmd.addr_sel = mmle_pkg::ADDR_CNT;
        if (!stat.cur_known || stat.out_free) begin
          cmd.emit_entry = stat.cur_known;
          if (!stat.more_above || stat.cnt_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/mmle_dp.sv
// ----------------------------------------------------------------------------
// mmle_dp: datapath of the leader election block
// Node table, item and own id registers, reachability sets, broadcast
// counter and the result register.
// ----------------------------------------------------------------------------
module mmle_dp #(
  parameter int TBL = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  mmle_item_if.sink            item,
  mmle_result_if.source        result,
  mmle_cfg_if.sink             cfg,
  input  mmle_pkg::mmle_cmd_t  cmd,
  output mmle_pkg::mmle_stat_t stat
);

  localparam int IW = $clog2(TBL);

  function automatic logic [IW-1:0] lowest(input logic [TBL-1:0] v);
    logic [IW-1:0] idx;
    idx = '0;
    for (int i = TBL - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IW'(i);
      end
    end
    return idx;
  endfunction

  logic [TBL-1:0]   known;
  logic [31:0]      clk_mem [TBL];
  logic [TBL-1:0]   nb_mem [TBL];

  logic [1:0]       it_act;
  logic [3:0]       it_id;
  logic [31:0]      it_clock;
  logic [TBL-1:0]   it_mask;
  logic             it_last;
  logic [3:0]       own;

  logic [TBL-1:0]   reach;
  logic [TBL-1:0]   visited;
  logic [IW-1:0]    cnt;

  logic             out_valid;
  logic             out_kind;
  logic [3:0]       out_leader_id;
  logic             out_leader_valid;
  logic [3:0]       out_entry_id;
  logic [31:0]      out_entry_clock;
  logic [15:0]      out_entry_mask;
  logic             out_last;

  logic             item_fire;
  logic             cfg_fire;
  logic             id_ok;
  logic             own_ok;
  logic             cfg_ok;
  logic [IW-1:0]    id_idx;
  logic [IW-1:0]    own_idx;
  logic [TBL-1:0]   id_bit;
  logic [TBL-1:0]   own_bit;
  logic [TBL-1:0]   pend;
  logic [IW-1:0]    pidx;
  logic [IW-1:0]    rd_addr;
  logic             rd_known;
  logic [31:0]      rd_clock;
  logic [TBL-1:0]   rd_mask;
  logic [TBL-1:0]   cnt_bit;
  logic [TBL-1:0]   above;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [31:0]      wclock;
  logic [TBL-1:0]   wmask;
  logic [TBL-1:0]   base;
  logic             out_free;

  assign item_fire = item.valid && item.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign item.ready = cmd.item_ready;
  assign cfg.ready  = cmd.cfg_ready;

  assign id_ok   = int'(it_id) < TBL;
  assign own_ok  = int'(own) < TBL;
  assign cfg_ok  = int'(cfg.data) < TBL;
  assign id_idx  = it_id[IW-1:0];
  assign own_idx = own[IW-1:0];
  assign id_bit  = TBL'(1) << id_idx;
  assign own_bit = TBL'(1) << own_idx;
  assign pend    = reach & ~visited;
  assign pidx    = lowest(pend);
  assign cnt_bit = TBL'(1) << cnt;
  assign above   = known & ~((cnt_bit << 1) - TBL'(1));

  always_comb begin
    case (cmd.addr_sel)
      mmle_pkg::ADDR_ITEM: rd_addr = id_idx;
      mmle_pkg::ADDR_OWN:  rd_addr = own_idx;
      mmle_pkg::ADDR_PEND: rd_addr = pidx;
      mmle_pkg::ADDR_CNT:  rd_addr = cnt;
      default:             rd_addr = cnt;
    endcase
  end

  assign rd_known = known[rd_addr];
  assign rd_clock = clk_mem[rd_addr];
  assign rd_mask  = nb_mem[rd_addr];

  always_comb begin
    we     = 1'b0;
    waddr  = own_idx;
    wclock = '0;
    wmask  = own_bit;
    base   = rd_known ? rd_mask : own_bit;
    if (cfg_fire) begin
      we    = cfg_ok;
      waddr = cfg.data[IW-1:0];
      wmask = TBL'(1) << cfg.data[IW-1:0];
    end else if (cmd.merge) begin
      we     = id_ok && (!rd_known || ($signed(it_clock) > $signed(rd_clock)));
      waddr  = id_idx;
      wclock = it_clock;
      wmask  = it_mask;
    end else if (cmd.peer_upd) begin
      we     = own_ok;
      wclock = rd_known ? rd_clock : 32'd0;
      if (!id_ok) begin
        wmask = base;
      end else if (it_act == mmle_pkg::ACT_CONNECT) begin
        wmask = base | id_bit;
      end else begin
        wmask = base & ~id_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
      own   <= '0;
    end else begin
      if (we) begin
        known[waddr] <= 1'b1;
      end
      if (cfg_fire) begin
        own <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      clk_mem[waddr] <= wclock;
      nb_mem[waddr]  <= wmask;
    end
    if (item_fire) begin
      it_act   <= item.action;
      it_id    <= item.node_id;
      it_clock <= item.node_clock;
      it_mask  <= item.neighbour_mask[TBL-1:0];
      it_last  <= item.message_last;
    end
    if (cmd.reach_init) begin
      if (own_ok && rd_known) begin
        reach   <= rd_mask;
        visited <= own_bit;
      end else begin
        reach   <= '0;
        visited <= '0;
      end
    end else if (cmd.reach_step) begin
      visited <= visited | (TBL'(1) << pidx);
      if (rd_known) begin
        reach <= reach | rd_mask;
      end
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + IW'(1);
    end
  end

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_leader || cmd.emit_entry) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_leader) begin
      out_kind         <= mmle_pkg::KIND_LEADER;
      out_leader_id    <= (|reach) ? 4'(lowest(reach)) : 4'd0;
      out_leader_valid <= |reach;
      out_entry_id     <= '0;
      out_entry_clock  <= '0;
      out_entry_mask   <= '0;
      out_last         <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_kind         <= mmle_pkg::KIND_ENTRY;
      out_leader_id    <= '0;
      out_leader_valid <= 1'b0;
      out_entry_id     <= 4'(cnt);
      out_entry_clock  <= rd_clock;
      out_entry_mask   <= 16'(rd_mask);
      out_last         <= !(|above);
    end
  end

  assign result.valid        = out_valid;
  assign result.kind         = out_kind;
  assign result.leader_id    = out_leader_id;
  assign result.leader_valid = out_leader_valid;
  assign result.entry_id     = out_entry_id;
  assign result.entry_clock  = out_entry_clock;
  assign result.entry_mask   = out_entry_mask;
  assign result.last         = out_last;

  assign stat.item_fire  = item_fire;
  assign stat.cfg_valid  = cfg.valid;
  assign stat.act        = it_act;
  assign stat.msg_last   = it_last;
  assign stat.pend_any   = |pend;
  assign stat.cur_known  = rd_known;
  assign stat.more_above = |above;
  assign stat.cnt_last   = (cnt == IW'(TBL - 1));
  assign stat.out_free   = out_free;

endmodule

>>> tb/mmle_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmle_checker: result predictor and scoreboard for the leader election block
// Watches the item, result and configuration channels. Keeps its own copy of
// the node table and the own id, works out the results of every accepted item
// and compares each result beat field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module mmle_checker
  import mmle_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  mmle_item_if   item,
  mmle_result_if result,
  mmle_cfg_if    cfg,
  output int     errors,
  output int     outstanding
);

  localparam int TABLE_DEPTH = 16;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic                          kind;
    logic [ID_WIDTH-1:0]           leader_id;
    logic                          leader_valid;
    logic [ID_WIDTH-1:0]           entry_id;
    logic signed [CLOCK_WIDTH-1:0] entry_clock;
    logic [MASK_WIDTH-1:0]         entry_mask;
    logic                          last;
  } mesh_result_t;

  logic [ID_WIDTH-1:0]           own_id;
  logic                          known [TABLE_DEPTH];
  logic signed [CLOCK_WIDTH-1:0] clock_tab [TABLE_DEPTH];
  logic [MASK_WIDTH-1:0]         nbr_tab [TABLE_DEPTH];
  mesh_result_t                  expected_q [$];
  int                            result_beats;

  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) begin
      $display("%0t ns: result beat %0d: %s", $time, result_beats, msg);
    end
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic void install_own_entry();
    known[own_id] = 1'b1;
    clock_tab[own_id] = '0;
    nbr_tab[own_id] = MASK_WIDTH'(1) << own_id;
  endfunction

  function automatic mesh_result_t elect_leader();
    mesh_result_t r;
    logic [MASK_WIDTH-1:0] reach;
    logic [MASK_WIDTH-1:0] seen;
    bit grown;
    r = '0;
    r.kind = KIND_LEADER;
    r.last = 1'b1;
    reach = '0;
    if (known[own_id]) begin
      reach = nbr_tab[own_id];
      seen = MASK_WIDTH'(1) << own_id;
      grown = 1'b1;
      while (grown) begin
        grown = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (reach[k] && !seen[k]) begin
            seen[k] = 1'b1;
            if (known[k]) begin
              reach |= nbr_tab[k];
            end
            grown = 1'b1;
          end
        end
      end
    end
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (reach[k]) begin
        r.leader_id = ID_WIDTH'(k);
        r.leader_valid = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void queue_table_run();
    mesh_result_t r;
    int count;
    count = 0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (known[k]) begin
        r = '0;
        r.kind = KIND_ENTRY;
        r.entry_id = ID_WIDTH'(k);
        r.entry_clock = clock_tab[k];
        r.entry_mask = nbr_tab[k];
        expected_q.push_back(r);
        count++;
      end
    end
    if (count > 0) begin
      expected_q[expected_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void predict_item(logic [1:0] act, logic [ID_WIDTH-1:0] id,
                                       logic signed [CLOCK_WIDTH-1:0] stamp,
                                       logic [MASK_WIDTH-1:0] mask, logic msg_last);
    case (act)
      ACT_ENTRY: begin
        if (!known[id] || stamp > clock_tab[id]) begin
          known[id] = 1'b1;
          clock_tab[id] = stamp;
          nbr_tab[id] = mask;
        end
        if (msg_last) begin
          expected_q.push_back(elect_leader());
        end
      end
      ACT_CONNECT, ACT_DISCONNECT: begin
        if (!known[own_id]) begin
          install_own_entry();
        end
        if (act == ACT_CONNECT) begin
          nbr_tab[own_id] |= MASK_WIDTH'(1) << id;
        end else begin
          nbr_tab[own_id] &= ~(MASK_WIDTH'(1) << id);
        end
        queue_table_run();
      end
      default: begin
        expected_q.push_back(elect_leader());
      end
    endcase
  endfunction

  task automatic compare_result();
    mesh_result_t got;
    mesh_result_t want;
    got.kind = result.kind;
    got.leader_id = result.leader_id;
    got.leader_valid = result.leader_valid;
    got.entry_id = result.entry_id;
    got.entry_clock = result.entry_clock;
    got.entry_mask = result.entry_mask;
    got.last = result.last;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat, kind %0d id %0d", got.kind, got.entry_id));
    end else begin
      want = expected_q.pop_front();
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("leader_id", 32'(got.leader_id), 32'(want.leader_id));
      check_field("leader_valid", 32'(got.leader_valid), 32'(want.leader_valid));
      check_field("entry_id", 32'(got.entry_id), 32'(want.entry_id));
      check_field("entry_clock", got.entry_clock, want.entry_clock);
      check_field("entry_mask", 32'(got.entry_mask), 32'(want.entry_mask));
      check_field("last", 32'(got.last), 32'(want.last));
    end
    result_beats++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_id = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        known[k] = 1'b0;
        clock_tab[k] = '0;
        nbr_tab[k] = '0;
      end
      expected_q.delete();
      errors = 0;
      result_beats = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        own_id = cfg.data;
        install_own_entry();
      end
      if (item.valid && item.ready) begin
        predict_item(item.action, item.node_id, item.node_clock, item.neighbour_mask,
                     item.message_last);
      end
      if (result.valid && result.ready) begin
        compare_result();
      end
    end
    outstanding = expected_q.size();
  end

endmodule

>>> tb/mesh_min_id_leader_election_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_min_id_leader_election_tb: testbench of the leader election block
// Drives received entries, peer changes and leader queries with random gaps
// on both sides, rewrites the own node id between phases, and leaves the
// checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module mesh_min_id_leader_election_tb;
  import mmle_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 70;
  localparam int HOLD_CYCLES   = 300;

  logic clk;
  logic rst;

  mmle_item_if   item ();
  mmle_result_if result ();
  mmle_cfg_if    cfg ();

  int mismatches;
  int outstanding;
  int items_sent;
  int gossip_stamp;
  int cycle_count;
  int hold_left;
  bit hold_done;
  bit hold_go;
  bit no_idle;

  mesh_min_id_leader_election #(
    .MAX_NODES(16)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  mmle_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .errors      (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      result.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      result.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (no_idle) begin
      result.ready <= 1'b1;
    end else begin
      result.ready <= ($urandom_range(0, 99) >= 29);
    end
  end

  function automatic logic [CLOCK_WIDTH-1:0] pick_clock();
    if ($urandom_range(0, 99) < 4) begin
      return $urandom;
    end
    return CLOCK_WIDTH'(gossip_stamp + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic logic [MASK_WIDTH-1:0] pick_mask();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return MASK_WIDTH'($urandom_range(0, 65535));
    end
    if (pick < 25) begin
      return '0;
    end
    return (MASK_WIDTH'(1) << $urandom_range(0, 15)) | (MASK_WIDTH'(1) << $urandom_range(0, 15));
  endfunction

  task automatic send_item(logic [1:0] act, logic [ID_WIDTH-1:0] id,
                           logic [CLOCK_WIDTH-1:0] stamp, logic [MASK_WIDTH-1:0] mask,
                           logic msg_last);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.action <= act;
    item.node_id <= id;
    item.node_clock <= stamp;
    item.neighbour_mask <= mask;
    item.message_last <= msg_last;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_own_id(logic [ID_WIDTH-1:0] id);
    cfg.valid <= 1'b1;
    cfg.data <= id;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic settle();
    item.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_step();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      len = $urandom_range(1, 5);
      gossip_stamp++;
      for (int n = 1; n <= len; n++) begin
        send_item(ACT_ENTRY, ID_WIDTH'($urandom_range(0, 15)), pick_clock(), pick_mask(),
                  n == len);
      end
    end else if (pick < 70) begin
      send_item(ACT_CONNECT, ID_WIDTH'($urandom_range(0, 15)), $urandom,
                MASK_WIDTH'($urandom), 1'($urandom_range(0, 1)));
    end else if (pick < 80) begin
      send_item(ACT_DISCONNECT, ID_WIDTH'($urandom_range(0, 15)), $urandom,
                MASK_WIDTH'($urandom), 1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      send_item(ACT_QUERY, ID_WIDTH'($urandom_range(0, 15)), $urandom,
                MASK_WIDTH'($urandom), 1'($urandom_range(0, 1)));
    end else if (pick < 95) begin
      send_item(ACT_ENTRY, ID_WIDTH'($urandom_range(0, 15)), pick_clock(), pick_mask(),
                1'b0);
    end else begin
      send_item(2'($urandom_range(0, 3)), ID_WIDTH'($urandom_range(0, 15)), $urandom,
                MASK_WIDTH'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int target;
    rst = 1'b1;
    items_sent = 0;
    gossip_stamp = 0;
    no_idle = 1'b0;
    hold_go = 1'b0;
    item.valid = 1'b0;
    item.action = ACT_ENTRY;
    item.node_id = '0;
    item.node_clock = '0;
    item.neighbour_mask = '0;
    item.message_last = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // No own entry exists yet: the leader is invalid until a peer change installs it.
    send_item(ACT_QUERY, 4'd0, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_ENTRY, 4'd5, 32'd10, 16'h0021, 1'b0);
    send_item(ACT_ENTRY, 4'd5, 32'd10, 16'hFFFF, 1'b1);
    send_item(ACT_DISCONNECT, 4'd4, 32'd0, 16'h0000, 1'b0);

    settle();
    write_own_id(4'd15);
    send_item(ACT_CONNECT, 4'd5, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_QUERY, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(ACT_ENTRY, 4'd15, 32'h7FFF_FFFF, 16'h0000, 1'b1);
    send_item(ACT_ENTRY, 4'd15, 32'd5, 16'hFFFF, 1'b1);
    send_item(ACT_ENTRY, 4'd9, 32'h8000_0000, 16'h0200, 1'b0);
    send_item(ACT_ENTRY, 4'd9, 32'h8000_0000, 16'h0001, 1'b1);
    send_item(ACT_ENTRY, 4'd9, 32'h8000_0001, 16'h0001, 1'b1);
    send_item(ACT_CONNECT, 4'd9, 32'd0, 16'h0000, 1'b0);

    settle();
    write_own_id(4'd0);
    send_item(ACT_ENTRY, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(ACT_ENTRY, 4'd3, 32'd1, 16'h5555, 1'b0);
    send_item(ACT_ENTRY, 4'd12, 32'd2, 16'hAAAA, 1'b1);
    send_item(ACT_CONNECT, 4'd3, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_QUERY, 4'd0, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_DISCONNECT, 4'd0, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_QUERY, 4'd0, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_CONNECT, 4'd15, 32'd0, 16'h0000, 1'b0);
    send_item(ACT_DISCONNECT, 4'd15, 32'd0, 16'h0000, 1'b0);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: write_own_id(ID_WIDTH'($urandom_range(1, 14)));
        1: write_own_id(4'd15);
        3: write_own_id(4'd0);
        default: write_own_id(ID_WIDTH'($urandom_range(0, 15)));
      endcase
      no_idle <= (p == 2);
      hold_go <= (p == 3);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_step();
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
